@@ rtl/core/cwpb_pkg.sv @@
// Types and constants shared by the census-weighted pixel blend modules.
`default_nettype none

package cwpb_pkg;

    localparam int PIX_W   = 20;
    localparam int OUT_W   = 16;
    localparam int COL_W   = 12;
    localparam int WIDTH_W = 13;
    localparam int DIV_W   = 4;
    localparam int CLAMP_W = 16;
    localparam int EXT_W   = 14;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 2;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_CENSUS_DIVISOR = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CLAMP_LOW      = 2'd2;
    localparam logic [ADDR_W-1:0] REG_CLAMP_HIGH     = 2'd3;

    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH    = 13'd1920;
    localparam logic [DIV_W-1:0]   RST_CENSUS_DIVISOR = 4'd8;
    localparam logic [CLAMP_W-1:0] RST_CLAMP_LOW      = 16'd0;
    localparam logic [CLAMP_W-1:0] RST_CLAMP_HIGH     = 16'd255;

    localparam logic [DIV_W-1:0] DIV_MIN = 4'd8;
    localparam logic [DIV_W-1:0] DIV_MAX = 4'd9;

    localparam logic [1:0] ROWS_FULL = 2'd2;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // blend arithmetic widths
    localparam int N_W = PIX_W + 5;
    localparam int M_W = PIX_W + 1;
    localparam int P_W = M_W + PIX_W;

    // floor(m / 9) = (m * RECIP_K) >> RECIP_SHIFT, exact for m < 2**21
    localparam logic [PIX_W-1:0] RECIP_K     = 20'd932068;
    localparam int               RECIP_SHIFT = 23;

    typedef struct packed {
        logic [WIDTH_W-1:0] image_width;
        logic [DIV_W-1:0]   census_divisor;
        logic [CLAMP_W-1:0] clamp_low;
        logic [CLAMP_W-1:0] clamp_high;
    } cfg_t;

    // one line store entry: the two stored rows of both images at a column
    typedef struct packed {
        logic [PIX_W-1:0] f_mid;
        logic [PIX_W-1:0] f_top;
        logic [PIX_W-1:0] p_mid;
        logic [PIX_W-1:0] p_top;
    } line_pair_t;

    // one window column plus what the front decided about the item
    typedef struct packed {
        logic [PIX_W-1:0] p_top;
        logic [PIX_W-1:0] p_mid;
        logic [PIX_W-1:0] p_bot;
        logic [PIX_W-1:0] f_top;
        logic [PIX_W-1:0] f_mid;
        logic [PIX_W-1:0] f_bot;
        logic             emit;
        logic [COL_W-1:0] column;
        logic             row_end;
    } col_item_t;

endpackage

`default_nettype wire

@@ rtl/core/census_weighted_pixel_blend.sv @@
// An item passes the front, queue, window, s1 to s4 and output registers. Throughput: one
// item per cycle while the queue has room, set by the line store with one read port used
// at accept and one write port used at push; a 4-entry queue decouples the two halves.
// Reset (aresetn, synchronous): counters, queue and valids clear, registers load
// defaults; line store contents stay undefined until written, no clearing pass.
`default_nettype none

module census_weighted_pixel_blend
    import cwpb_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [2*PIX_W-1:0]  s_tdata,   // plain_sample, filtered_sample
    input  wire logic                s_tuser,   // frame_start
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,   // blended_pixel, out_column, zero pad
    output logic                     m_tlast
);

    cfg_t      cfg_reg;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    col_item_t q_in;
    col_item_t q_out;

    logic [OUT_W-1:0] blended;
    logic [COL_W-1:0] column;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width    <= RST_IMAGE_WIDTH;
            cfg_reg.census_divisor <= RST_CENSUS_DIVISOR;
            cfg_reg.clamp_low      <= RST_CLAMP_LOW;
            cfg_reg.clamp_high     <= RST_CLAMP_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_wdata[WIDTH_W-1:0];
                end
                REG_CENSUS_DIVISOR: begin
                    cfg_reg.census_divisor <= cfg_wdata[DIV_W-1:0];
                end
                REG_CLAMP_LOW: begin
                    cfg_reg.clamp_low <= cfg_wdata[CLAMP_W-1:0];
                end
                REG_CLAMP_HIGH: begin
                    cfg_reg.clamp_high <= cfg_wdata[CLAMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cwpb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_plain       (s_tdata[PIX_W-1:0]),
        .s_filtered    (s_tdata[2*PIX_W-1:PIX_W]),
        .s_frame_start (s_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    cwpb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    cwpb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_blended (blended),
        .m_column  (column),
        .m_row_end (m_tlast)
    );

    assign m_tdata = {4'd0, column, blended};

endmodule

`default_nettype wire

@@ rtl/core/cwpb_front.sv @@
// Front: row/column tracking, line stores and window column assembly.
`default_nettype none

module cwpb_front
    import cwpb_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_plain,
    input  wire logic [PIX_W-1:0] s_filtered,
    input  wire logic             s_frame_start,
    input  wire logic             q_full,
    output logic                  q_push,
    output col_item_t             q_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [EXT_W-1:0] MAXW_EXT = EXT_W'(MAX_WIDTH);

    line_pair_t line_mem [MAX_WIDTH];

    logic [AW-1:0]    col_reg;
    logic [1:0]       rows_reg;
    logic             f1_vld_reg;
    logic [PIX_W-1:0] f1_p_reg;
    logic [PIX_W-1:0] f1_f_reg;
    logic [AW-1:0]    f1_addr_reg;
    logic             f1_emit_reg;
    logic [COL_W-1:0] f1_col_reg;
    logic             f1_end_reg;
    line_pair_t       rd_reg;
    line_pair_t       wr_data;

    logic             accept;
    logic [AW-1:0]    cur_col;
    logic [1:0]       cur_rows;
    logic [EXT_W-1:0] w_ext;
    logic [EXT_W-1:0] w_sat;
    logic [EXT_W-1:0] c_ext;
    logic             last;
    logic             emit;

    assign q_push   = f1_vld_reg && !q_full;
    assign s_tready = !f1_vld_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    assign cur_col  = s_frame_start ? '0 : col_reg;
    assign cur_rows = s_frame_start ? 2'd0 : rows_reg;
    assign w_ext    = EXT_W'(cfg.image_width);
    assign w_sat    = (w_ext < EXT_W'(3)) ? EXT_W'(3) :
                      (w_ext > MAXW_EXT) ? MAXW_EXT : w_ext;
    assign c_ext    = EXT_W'(cur_col);
    assign last     = c_ext >= (w_sat - EXT_W'(1));
    assign emit     = (cur_rows == ROWS_FULL) && (c_ext >= EXT_W'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            rows_reg   <= 2'd0;
            f1_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg  <= last ? '0 : cur_col + AW'(1);
                rows_reg <= (last && cur_rows != ROWS_FULL) ? cur_rows + 2'd1 : cur_rows;
            end
            if (accept) begin
                f1_vld_reg <= 1'b1;
            end else if (q_push) begin
                f1_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_p_reg    <= s_plain;
            f1_f_reg    <= s_filtered;
            f1_addr_reg <= cur_col;
            f1_emit_reg <= emit;
            f1_col_reg  <= COL_W'(c_ext - EXT_W'(1));
            f1_end_reg  <= last;
        end
    end

    assign wr_data.f_mid = f1_f_reg;
    assign wr_data.f_top = rd_reg.f_mid;
    assign wr_data.p_mid = f1_p_reg;
    assign wr_data.p_top = rd_reg.p_mid;

    // line store: write on push, read on accept, forward a same-column write
    always_ff @(posedge aclk) begin
        if (q_push) begin
            line_mem[f1_addr_reg] <= wr_data;
        end
        if (accept) begin
            if (q_push && f1_addr_reg == cur_col) begin
                rd_reg <= wr_data;
            end else begin
                rd_reg <= line_mem[cur_col];
            end
        end
    end

    assign q_data.p_top   = rd_reg.p_top;
    assign q_data.p_mid   = rd_reg.p_mid;
    assign q_data.p_bot   = f1_p_reg;
    assign q_data.f_top   = rd_reg.f_top;
    assign q_data.f_mid   = rd_reg.f_mid;
    assign q_data.f_bot   = f1_f_reg;
    assign q_data.emit    = f1_emit_reg;
    assign q_data.column  = f1_col_reg;
    assign q_data.row_end = f1_end_reg;

endmodule

`default_nettype wire

@@ rtl/core/cwpb_queue.sv @@
// Short queue of window columns between front and back.
`default_nettype none

module cwpb_queue
    import cwpb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire col_item_t push_data,
    output logic           full,
    input  wire logic      pop,
    output col_item_t      pop_data,
    output logic           empty
);

    col_item_t          slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full     = count_reg == QCNT_W'(Q_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cwpb_back.sv @@
// Back: 3x3 windows, census mismatch count, weighted blend, rounding and clamp.
`default_nettype none

module cwpb_back
    import cwpb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             q_empty,
    output logic                  q_pop,
    input  wire col_item_t        q_data,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_blended,
    output logic [COL_W-1:0]      m_column,
    output logic                  m_row_end
);

    // quotient reaches 65536 when both centres sit near full scale
    localparam int Q_W = OUT_W + 1;

    logic [PIX_W-1:0] pwin_reg [9];
    logic [PIX_W-1:0] fwin_reg [9];
    logic             wv_vld_reg;
    logic [COL_W-1:0] wv_col_reg;
    logic             wv_end_reg;

    logic             s1_vld_reg;
    logic [3:0]       s1_h_reg;
    logic [PIX_W-1:0] s1_cp_reg;
    logic [PIX_W-1:0] s1_cf_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_end_reg;

    logic             s2_vld_reg;
    logic [N_W-1:0]   s2_n_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic             s2_end_reg;

    logic             s3_vld_reg;
    logic [M_W-1:0]   s3_m_reg;
    logic [COL_W-1:0] s3_col_reg;
    logic             s3_end_reg;

    logic             s4_vld_reg;
    logic [Q_W-1:0]   s4_q_reg;
    logic [COL_W-1:0] s4_col_reg;
    logic             s4_end_reg;

    logic             out_vld_reg;
    logic [OUT_W-1:0] out_pix_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_end_reg;

    logic             adv;
    logic [3:0]       h;
    logic [DIV_W-1:0] d_sat;
    logic [N_W-1:0]   n_next;
    logic [M_W-1:0]   m_next;
    logic [P_W-1:0]   recip_prod;
    logic [Q_W-1:0]   q_next;
    logic [OUT_W-1:0] hi_lim;
    logic [OUT_W-1:0] pix_next;

    assign adv   = !out_vld_reg || m_tready;
    assign q_pop = adv && !q_empty;

    // window shift, one column per popped item
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int r = 0; r < 3; r++) begin
                pwin_reg[r*3]   <= pwin_reg[r*3+1];
                pwin_reg[r*3+1] <= pwin_reg[r*3+2];
                fwin_reg[r*3]   <= fwin_reg[r*3+1];
                fwin_reg[r*3+1] <= fwin_reg[r*3+2];
            end
            pwin_reg[2] <= q_data.p_top;
            pwin_reg[5] <= q_data.p_mid;
            pwin_reg[8] <= q_data.p_bot;
            fwin_reg[2] <= q_data.f_top;
            fwin_reg[5] <= q_data.f_mid;
            fwin_reg[8] <= q_data.f_bot;
        end
    end

    always_comb begin
        h = 4'd0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                h = h + 4'((pwin_reg[k] < pwin_reg[4]) ^ (fwin_reg[k] < fwin_reg[4]));
            end
        end
    end

    assign d_sat = (cfg.census_divisor < DIV_MIN) ? DIV_MIN :
                   (cfg.census_divisor > DIV_MAX) ? DIV_MAX : cfg.census_divisor;

    assign n_next = N_W'(s1_h_reg) * N_W'(s1_cp_reg)
                  + N_W'(d_sat - s1_h_reg) * N_W'(s1_cf_reg);

    assign m_next = M_W'((s2_n_reg + (N_W'(d_sat) << 3)) >> 4);

    assign recip_prod = P_W'(s3_m_reg) * P_W'(RECIP_K);
    assign q_next     = (d_sat == DIV_MAX) ? Q_W'(recip_prod >> RECIP_SHIFT)
                                           : Q_W'(s3_m_reg >> 3);

    assign hi_lim   = (s4_q_reg > Q_W'(cfg.clamp_high)) ? cfg.clamp_high
                                                        : OUT_W'(s4_q_reg);
    assign pix_next = (hi_lim < cfg.clamp_low) ? cfg.clamp_low : hi_lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            wv_vld_reg  <= q_pop && q_data.emit;
            s1_vld_reg  <= wv_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wv_col_reg  <= q_data.column;
            wv_end_reg  <= q_data.row_end;
            s1_h_reg    <= h;
            s1_cp_reg   <= pwin_reg[4];
            s1_cf_reg   <= fwin_reg[4];
            s1_col_reg  <= wv_col_reg;
            s1_end_reg  <= wv_end_reg;
            s2_n_reg    <= n_next;
            s2_col_reg  <= s1_col_reg;
            s2_end_reg  <= s1_end_reg;
            s3_m_reg    <= m_next;
            s3_col_reg  <= s2_col_reg;
            s3_end_reg  <= s2_end_reg;
            s4_q_reg    <= q_next;
            s4_col_reg  <= s3_col_reg;
            s4_end_reg  <= s3_end_reg;
            out_pix_reg <= pix_next;
            out_col_reg <= s4_col_reg;
            out_end_reg <= s4_end_reg;
        end
    end

    assign m_tvalid  = out_vld_reg;
    assign m_blended = out_pix_reg;
    assign m_column  = out_col_reg;
    assign m_row_end = out_end_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the census-weighted 3x3 pixel blend over its stream ports.
`timescale 1ns / 100ps

module tb;
    import cwpb_pkg::*;

    localparam int MAX_W        = 4096;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic [OUT_W-1:0] blended;
        logic [COL_W-1:0] column;
        logic             row_end;
    } blend_res_t;

    typedef struct packed {
        logic [PIX_W-1:0] plain;
        logic [PIX_W-1:0] filt;
        logic             fs;
        logic             typed;
        blend_res_t       res;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_t;
    typedef enum int {PIX_FULL, PIX_TIES, PIX_TOP, PIX_CLUSTER} pix_mode_t;

    localparam blend_res_t NO_RES = '0;
    localparam logic [PIX_W-1:0] PMAX = 20'hFFFFF;
    localparam logic [PIX_W-1:0] FLAT = 20'h00050;

    // width 3, reset divisor and clamps; all-equal frame, then a spike in plain only
    localparam dir_row_t DIR_ROWS [21] = '{
        '{PMAX, PMAX, 1'b1, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b0, NO_RES},
        '{PMAX, PMAX, 1'b0, 1'b1, '{16'd255, 12'd1, 1'b1}},
        '{20'h0, FLAT, 1'b1, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h00100, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b0, NO_RES},
        '{20'h0, FLAT, 1'b0, 1'b1, '{16'd16, 12'd1, 1'b1}},
        '{PMAX, 20'h0, 1'b0, 1'b0, NO_RES},
        '{20'h12345, 20'hABCDE, 1'b0, 1'b0, NO_RES},
        '{20'h00001, 20'hFFFFE, 1'b0, 1'b0, NO_RES}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [2*PIX_W-1:0]  s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tlast;

    // shadow of the block: registers, two line rows per image, 3x3 windows
    logic [WIDTH_W-1:0]  width_reg = RST_IMAGE_WIDTH;
    logic [DIV_W-1:0]    div_reg   = RST_CENSUS_DIVISOR;
    logic [CLAMP_W-1:0]  low_reg   = RST_CLAMP_LOW;
    logic [CLAMP_W-1:0]  high_reg  = RST_CLAMP_HIGH;
    logic [PIX_W-1:0]    plain_older [MAX_W];
    logic [PIX_W-1:0]    plain_prev  [MAX_W];
    logic [PIX_W-1:0]    filt_older  [MAX_W];
    logic [PIX_W-1:0]    filt_prev   [MAX_W];
    logic [PIX_W-1:0]    plain_win [9] = '{default: '0};
    logic [PIX_W-1:0]    filt_win  [9] = '{default: '0};
    int                  col_pos   = 0;
    int                  full_rows = 0;

    blend_res_t          pending_blends [$];
    blend_res_t          due_blend;
    int                  mismatch_count = 0;
    int                  random_items   = 0;
    int                  burst_left     = 0;
    bit [31:0]           rx_tick        = '0;
    rx_mode_t            rx_mode        = RX_OPEN;

    census_weighted_pixel_blend #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > MAX_W) return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic bit predict_blend(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] f,
                                         input logic fs, output blend_res_t r);
        int w, c, k, h, d;
        logic [PIX_W-1:0] pt, pm, ft, fm;
        logic [31:0] n, v;
        w = eff_width();
        if (fs) begin
            col_pos = 0;
            full_rows = 0;
        end
        c = col_pos;
        pt = plain_older[c];
        pm = plain_prev[c];
        ft = filt_older[c];
        fm = filt_prev[c];
        plain_older[c] = pm;
        plain_prev[c] = p;
        filt_older[c] = fm;
        filt_prev[c] = f;
        for (k = 0; k < 3; k++) begin
            plain_win[3*k]   = plain_win[3*k+1];
            plain_win[3*k+1] = plain_win[3*k+2];
            filt_win[3*k]    = filt_win[3*k+1];
            filt_win[3*k+1]  = filt_win[3*k+2];
        end
        plain_win[2] = pt;
        plain_win[5] = pm;
        plain_win[8] = p;
        filt_win[2] = ft;
        filt_win[5] = fm;
        filt_win[8] = f;
        r = '0;
        predict_blend = 1'b0;
        if (full_rows >= ROWS_FULL && c >= 2) begin
            d = (div_reg < DIV_MIN) ? int'(DIV_MIN) : (div_reg > DIV_MAX) ? int'(DIV_MAX)
                                                                          : int'(div_reg);
            h = 0;
            for (k = 0; k < 9; k++)
                if (k != 4 && ((plain_win[k] < plain_win[4]) != (filt_win[k] < filt_win[4])))
                    h++;
            n = h * plain_win[4] + (d - h) * filt_win[4];
            v = (n + 8 * d) / (16 * d);
            if (v > high_reg) v = high_reg;
            if (v < low_reg) v = low_reg;
            r.blended = v[OUT_W-1:0];
            r.column = COL_W'(c - 1);
            r.row_end = (c >= w - 1);
            predict_blend = 1'b1;
        end
        if (c >= w - 1) begin
            col_pos = 0;
            if (full_rows < ROWS_FULL) full_rows++;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_t m,
                                                    input logic [PIX_W-1:0] base);
        case (m)
            PIX_TIES:    return PIX_W'($urandom_range(0, 3));
            PIX_TOP:     return PMAX - PIX_W'($urandom_range(0, 3));
            PIX_CLUSTER: return base + PIX_W'($urandom_range(0, 63));
            default:     return PIX_W'($urandom());
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_IMAGE_WIDTH:    width_reg = WIDTH_W'(val);
            REG_CENSUS_DIVISOR: div_reg = DIV_W'(val);
            REG_CLAMP_LOW:      low_reg = CLAMP_W'(val);
            REG_CLAMP_HIGH:     high_reg = CLAMP_W'(val);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic push_item(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] f,
                             input logic fs, input logic typed, input blend_res_t typed_res);
        blend_res_t r;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        s_tdata <= {f, p};
        s_tuser <= fs;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (predict_blend(p, f, fs, r)) pending_blends.push_back(typed ? typed_res : r);
    endtask

    task automatic send_frame(input int rows, input bit fresh, input bit noisy);
        int i, w;
        logic fs;
        pix_mode_t m;
        logic [PIX_W-1:0] base;
        w = eff_width();
        m = pix_mode_t'($urandom_range(0, 3));
        base = PIX_W'($urandom_range(0, 20'hFFFBF));
        for (i = 0; i < rows * w; i++) begin
            fs = (fresh && i == 0) || (noisy && $urandom_range(0, 299) == 0);
            push_item(pick_pixel(m, base), pick_pixel(m, base), fs, 1'b0, NO_RES);
            random_items++;
        end
    endtask

    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (pending_blends.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[6:0] == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_tick % 5 == 0);
            default:   m_tready <= (rx_tick[3:0] < 3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blends.size() == 0) begin
                flag_mismatch($sformatf("unexpected item data %h last %b", m_tdata, m_tlast));
            end else begin
                due_blend = pending_blends.pop_front();
                if (m_tdata[OUT_W-1:0] !== due_blend.blended)
                    flag_mismatch($sformatf("blended %0d, expected %0d",
                                            m_tdata[OUT_W-1:0], due_blend.blended));
                if (m_tdata[OUT_W +: COL_W] !== due_blend.column)
                    flag_mismatch($sformatf("column %0d, expected %0d",
                                            m_tdata[OUT_W +: COL_W], due_blend.column));
                if (m_tlast !== due_blend.row_end)
                    flag_mismatch($sformatf("row end %b, expected %b at column %0d",
                                            m_tlast, due_blend.row_end, due_blend.column));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int prev_w;
        bit fresh;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_IMAGE_WIDTH;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_IMAGE_WIDTH, 3);
        foreach (DIR_ROWS[i])
            push_item(DIR_ROWS[i].plain, DIR_ROWS[i].filt, DIR_ROWS[i].fs,
                      DIR_ROWS[i].typed, DIR_ROWS[i].res);

        while (random_items < RANDOM_ITEMS) begin
            settle_pipeline();
            prev_w = eff_width();
            case ($urandom_range(0, 9)) inside
                0:       write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 2));
                [7:8]:   write_reg(REG_IMAGE_WIDTH, $urandom_range(13, 70));
                default: write_reg(REG_IMAGE_WIDTH, $urandom_range(3, 12));
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_CENSUS_DIVISOR, $urandom_range(0, 15));
            else
                write_reg(REG_CENSUS_DIVISOR, $urandom_range(DIV_MIN, DIV_MAX));
            case ($urandom_range(0, 4))
                0:       write_reg(REG_CLAMP_LOW, 0);
                1:       write_reg(REG_CLAMP_LOW, 65535);
                2:       write_reg(REG_CLAMP_LOW, $urandom_range(0, 65535));
                default: write_reg(REG_CLAMP_LOW, $urandom_range(0, 400));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_CLAMP_HIGH, 65535);
                1:       write_reg(REG_CLAMP_HIGH, $urandom_range(0, 65535));
                2:       write_reg(REG_CLAMP_HIGH, 255);
                default: write_reg(REG_CLAMP_HIGH, $urandom_range(0, 1023));
            endcase
            // a frame may run on across a width change only if the width did not grow
            fresh = (eff_width() > prev_w) || ($urandom_range(0, 1) == 1);
            repeat ($urandom_range(1, 3)) begin
                send_frame($urandom_range(3, 6), fresh, 1'b1);
                fresh = 1'b1;
            end
        end

        // last frame: top divisor over the full clamp range
        settle_pipeline();
        write_reg(REG_IMAGE_WIDTH, 30);
        write_reg(REG_CENSUS_DIVISOR, DIV_MAX);
        write_reg(REG_CLAMP_LOW, 0);
        write_reg(REG_CLAMP_HIGH, 65535);
        send_frame(3, 1'b1, 1'b0);

        settle_pipeline();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
